>>> rtl/aes_cbc_ciphertext_stealing_encrypt_defines.svh
// assertion macros shared by the checker
`ifndef AES_CBC_CIPHERTEXT_STEALING_ENCRYPT_DEFINES_SVH
`define AES_CBC_CIPHERTEXT_STEALING_ENCRYPT_DEFINES_SVH
// implication checked on every rising edge out of reset
`define ACS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ACS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> rtl/acs_pkg.sv
`default_nettype none
package acs_pkg;
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StShortMsg = 2'd1;
  localparam logic [1:0] StShortBlk = 2'd2;

  localparam logic [2:0] RegKeyHigh = 3'd0;
  localparam logic [2:0] RegKeyLow  = 3'd1;
  localparam logic [2:0] RegIvHigh  = 3'd2;
  localparam logic [2:0] RegIvLow   = 3'd3;
  localparam logic [2:0] RegVariant = 3'd4;

  localparam logic [1:0] VarCs1 = 2'd0;
  localparam logic [1:0] VarCs2 = 2'd1;
  localparam logic [1:0] VarCs3 = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_KEY, S_ENC, S_OUT1, S_OUT2
  } state_e;

  typedef logic [7:0] sbox_tbl_t [256];
  localparam sbox_tbl_t Sbox = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits 127-8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(c*4+w) -: 8] = Sbox[s[127 - 8*((((c+w)%4)*4)+w) -: 8]];
      end
    end
    sub_shift = r;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, al;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 8*(c*4)   -: 8];
      a1 = s[127 - 8*(c*4+1) -: 8];
      a2 = s[127 - 8*(c*4+2) -: 8];
      a3 = s[127 - 8*(c*4+3) -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      r[127 - 8*(c*4)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      r[127 - 8*(c*4+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      r[127 - 8*(c*4+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      r[127 - 8*(c*4+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_cols = r;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // keep the first d bytes
  function automatic logic [127:0] keep_mask(input logic [4:0] d);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) m[127 - 8*i -: 8] = (5'(i) < d) ? 8'hff : 8'h00;
    keep_mask = m;
  endfunction
endpackage
`default_nettype wire

>>> rtl/aes_cbc_ciphertext_stealing_encrypt.sv
// channel | direction | handshake    | payload
// in      | input     | valid, stall | in_high, in_low, in_count, in_last
// out     | output    | valid, stall | out_high, out_low, out_count, out_last, status
// cfg     | input     | valid, ready | index, data
// a block goes through the transfer, the initial key addition, then ten passes
// through one shared round unit, each round key derived in the same cycle as its round.
// error items skip the key addition and the rounds; each result is shown in an output state.
// reset clears the control state, registers to reset values; keys derive on the fly.
// a stalled output holds its payload; no new item is taken until all results leave.
`default_nettype none
module aes_cbc_ciphertext_stealing_encrypt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] in_high_i,
  input  wire logic [63:0] in_low_i,
  input  wire logic [4:0]  in_count_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_high_o,
  output logic [63:0]      out_low_o,
  output logic [4:0]       out_count_o,
  output logic             out_last_o,
  output logic [1:0]       status_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import acs_pkg::*;

  state_e state_q, state_d;
  logic [127:0] key_q, iv_q, chain_q, held_q, s_q, rk_q, tail_q;
  logic [1:0]   var_q;
  logic         held_valid_q;
  logic [3:0]   round_q;
  logic [7:0]   rcon_q;
  logic [4:0]   d_q;
  logic         fin_q;     // current encryption is the final one of a held pair
  logic         emit_q;    // release the old held block after this encryption
  logic [127:0] o1_q, o2_q;
  logic [4:0]   c1_q, c2_q;
  logic         l1_q;
  logic [1:0]   st_q;
  logic [127:0] nk, rnd;
  logic         acc;
  logic [4:0]   dd;

  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign dd = (in_count_i == 5'd0) ? 5'd1 : (in_count_i > 5'd16) ? 5'd16 : in_count_i;
  assign nk = next_key(rk_q, rcon_q);
  assign rnd = (round_q == 4'd10) ? sub_shift(s_q) ^ nk : mix_cols(sub_shift(s_q)) ^ nk;

  // output view
  assign out_valid_o = (state_q == S_OUT1) || (state_q == S_OUT2);
  always_comb begin
    out_high_o = o1_q[127:64]; out_low_o = o1_q[63:0];
    out_count_o = c1_q; out_last_o = l1_q; status_o = st_q;
    if (state_q == S_OUT2) begin
      out_high_o = o2_q[127:64]; out_low_o = o2_q[63:0];
      out_count_o = c2_q; out_last_o = 1'b1; status_o = StOk;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc) begin
        if (dd < 5'd16 && (!in_last_i || !held_valid_q)) state_d = S_OUT1;
        else state_d = S_KEY;
      end
      S_KEY: state_d = S_ENC;
      S_ENC: if (round_q == 4'd10) begin
        if (fin_q || emit_q) state_d = S_OUT1;
        else if (l1_q) state_d = S_OUT1;
        else state_d = S_IDLE;
      end
      S_OUT1: if (!out_stall_i) state_d = fin_q ? S_OUT2 : S_IDLE;
      S_OUT2: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_valid_q <= 1'b0;
      key_q <= '0; iv_q <= '0; var_q <= VarCs3;
      fin_q <= 1'b0; emit_q <= 1'b0; l1_q <= 1'b0; st_q <= StOk;
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegKeyHigh: key_q[127:64] <= cfg_data_i;
          RegKeyLow:  key_q[63:0]   <= cfg_data_i;
          RegIvHigh:  iv_q[127:64]  <= cfg_data_i;
          RegIvLow:   iv_q[63:0]    <= cfg_data_i;
          RegVariant: var_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (acc) begin
          d_q <= dd;
          if (dd < 5'd16 && (!in_last_i || !held_valid_q)) begin
            o1_q <= '0; c1_q <= 5'd0; l1_q <= 1'b1;
            st_q <= in_last_i ? StShortMsg : StShortBlk;
            fin_q <= 1'b0;
            emit_q <= 1'b0;
            held_valid_q <= 1'b0;
          end else if (!held_valid_q) begin
            s_q <= {in_high_i, in_low_i} ^ iv_q;
            l1_q <= in_last_i;
            st_q <= StOk;
            fin_q <= 1'b0;
            emit_q <= 1'b0;
            held_valid_q <= !in_last_i;
          end else if (!in_last_i) begin
            s_q <= {in_high_i, in_low_i} ^ chain_q;
            emit_q <= 1'b1;
            o1_q <= held_q; c1_q <= 5'd16;
            l1_q <= 1'b0;
            st_q <= StOk;
            fin_q <= 1'b0;
          end else begin
            s_q <= ({in_high_i, in_low_i} & keep_mask(dd)) ^ held_q;
            tail_q <= held_q & keep_mask(dd);
            fin_q <= 1'b1;
            emit_q <= 1'b0;
            l1_q <= 1'b0;
            st_q <= StOk;
            held_valid_q <= 1'b0;
          end
        end
        S_KEY: begin
          s_q <= s_q ^ key_q;
          rk_q <= key_q;
          rcon_q <= 8'h01;
          round_q <= 4'd1;
        end
        S_ENC: begin
          s_q <= rnd;
          rk_q <= nk;
          rcon_q <= xtime(rcon_q);
          round_q <= round_q + 4'd1;
          if (round_q == 4'd10) begin
            if (fin_q) begin
              if (var_q == VarCs1 || (var_q == VarCs2 && d_q == 5'd16)) begin
                o1_q <= tail_q; c1_q <= d_q; o2_q <= rnd; c2_q <= 5'd16;
              end else begin
                o1_q <= rnd; c1_q <= 5'd16; o2_q <= tail_q; c2_q <= d_q;
              end
            end else if (l1_q) begin
              o1_q <= rnd; c1_q <= 5'd16;
            end else begin
              // new block becomes the chaining value and the held block
              chain_q <= rnd; held_q <= rnd; held_valid_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/acs_checker.sv
`default_nettype none
`include "aes_cbc_ciphertext_stealing_encrypt_defines.svh"
module acs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       out_last_o,
  input wire logic [1:0] status_o,
  input wire logic [4:0] out_count_o
);
  import acs_pkg::*;
  // no new transfer while a result is shown
  `ACS_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  // error results are last and empty
  `ACS_ASSERT_IMP(a_err, clk_i, rst_ni, out_valid_o && status_o != StOk,
    out_last_o && out_count_o == 5'd0)
  // accepted item makes the block busy next cycle
  `ACS_ASSERT_NEXT(a_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // stalled result holds
  `ACS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_count_o))
endmodule

bind aes_cbc_ciphertext_stealing_encrypt acs_checker u_acs_checker (.*);
`default_nettype wire

>>> bench/aes_cbc_ciphertext_stealing_encrypt_tb.sv
`default_nettype none
module aes_cbc_ciphertext_stealing_encrypt_tb;
  import acs_pkg::*;

  localparam logic [1:0] VarUnused = 2'd3;
  localparam int         DrainWait = 30;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
    logic        last;
    logic [1:0]  st;
  } cipher_blk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] in_high_i = '0;
  logic [63:0] in_low_i = '0;
  logic [4:0]  in_count_i = '0;
  logic        in_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_high_o;
  logic [63:0] out_low_o;
  logic [4:0]  out_count_o;
  logic        out_last_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes_cbc_ciphertext_stealing_encrypt dut (.*);

  // predictor copy of the block's registers and message state
  logic [127:0] key_reg = '0;
  logic [127:0] iv_reg = '0;
  logic [1:0]   variant_reg = VarCs3;
  logic [127:0] chain_blk = '0;
  logic [127:0] held_blk = '0;
  logic         held_ok = 1'b0;

  cipher_blk_t pending_ct[$];
  int          fails = 0;
  int          items_sent = 0;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;
  int          hold_left = 0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // aes-128 block encryption, byte 0 in the top bits
  function automatic logic [127:0] aes128_encrypt(input logic [127:0] k,
                                                   input logic [127:0] p);
    logic [127:0] s, t, rk;
    logic [31:0]  w0, w1, w2, w3, tw;
    logic [7:0]   rc, a0, a1, a2, a3, al;
    rk = k;
    s = p ^ rk;
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int row = 0; row < 4; row++)
          t[127 - 8*(c*4+row) -: 8] = Sbox[s[127 - 8*(((c+row)%4)*4+row) -: 8]];
      s = t;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[127 - 8*(c*4) -: 8];
          a1 = s[127 - 8*(c*4+1) -: 8];
          a2 = s[127 - 8*(c*4+2) -: 8];
          a3 = s[127 - 8*(c*4+3) -: 8];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[127 - 8*(c*4) -: 8]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          s[127 - 8*(c*4+1) -: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          s[127 - 8*(c*4+2) -: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          s[127 - 8*(c*4+3) -: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      // round key schedule
      {w0, w1, w2, w3} = rk;
      tw = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
      w0 = w0 ^ tw; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      rk = {w0, w1, w2, w3};
      rc = gf_dbl(rc);
      s = s ^ rk;
    end
    return s;
  endfunction

  function automatic logic [127:0] leading_bytes(input logic [127:0] b, input int d);
    for (int i = 0; i < 16; i++)
      if (i >= d) b[127 - 8*i -: 8] = 8'h00;
    return b;
  endfunction

  function automatic void push_ct(input logic [127:0] b, input int cnt, input logic last,
                                  input logic [1:0] st);
    cipher_blk_t e;
    e.hi = b[127:64]; e.lo = b[63:0]; e.cnt = 5'(cnt); e.last = last; e.st = st;
    pending_ct.push_back(e);
  endfunction

  // expected ciphertext for one accepted plaintext transfer
  function automatic void predict_cts(input logic [63:0] hi, input logic [63:0] lo,
                                      input logic [4:0] cnt, input logic last);
    int d;
    logic [127:0] c, tail;
    d = (cnt == 0) ? 1 : (cnt > 16) ? 16 : int'(cnt);
    if (!held_ok) chain_blk = iv_reg;
    if (d < 16 && (!last || !held_ok)) begin
      push_ct('0, 0, 1'b1, last ? StShortMsg : StShortBlk);
      held_ok = 1'b0;
    end else if (!last) begin
      if (held_ok) push_ct(held_blk, 16, 1'b0, StOk);
      c = aes128_encrypt(key_reg, {hi, lo} ^ chain_blk);
      chain_blk = c;
      held_blk = c;
      held_ok = 1'b1;
    end else if (!held_ok) begin
      push_ct(aes128_encrypt(key_reg, {hi, lo} ^ chain_blk), 16, 1'b1, StOk);
    end else begin
      c = aes128_encrypt(key_reg, leading_bytes({hi, lo}, d) ^ held_blk);
      tail = leading_bytes(held_blk, d);
      if (variant_reg == VarCs1 || (variant_reg == VarCs2 && d == 16)) begin
        push_ct(tail, d, 1'b0, StOk);
        push_ct(c, 16, 1'b1, StOk);
      end else begin
        push_ct(c, 16, 1'b0, StOk);
        push_ct(tail, d, 1'b1, StOk);
      end
      held_ok = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall pattern, counted here
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 250;
    end else if (hold_left == 0 && !quiet) begin
      case ($urandom_range(0, 19))
        0: hold_left = $urandom_range(10, 40);
        1, 2, 3, 4: hold_left = $urandom_range(1, 3);
        default: hold_left = 0;
      endcase
    end
    out_stall_i <= (hold_left > 0);
    if (hold_left > 0) hold_left = hold_left - 1;
  end

  // result checker
  always @(posedge clk_i) begin
    cipher_blk_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ct.size() == 0) begin
        $display("%0t: unexpected ciphertext transfer %h %h", $time, out_high_o, out_low_o);
        fails++;
      end else begin
        e = pending_ct.pop_front();
        if (out_high_o !== e.hi) begin
          $display("%0t: out_high exp %h act %h", $time, e.hi, out_high_o); fails++;
        end
        if (out_low_o !== e.lo) begin
          $display("%0t: out_low exp %h act %h", $time, e.lo, out_low_o); fails++;
        end
        if (out_count_o !== e.cnt) begin
          $display("%0t: out_count exp %0d act %0d", $time, e.cnt, out_count_o); fails++;
        end
        if (out_last_o !== e.last) begin
          $display("%0t: out_last exp %b act %b", $time, e.last, out_last_o); fails++;
        end
        if (status_o !== e.st) begin
          $display("%0t: status exp %0d act %0d", $time, e.st, status_o); fails++;
        end
      end
    end
  end

  // one plaintext transfer followed by an optional gap
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] cnt, input logic last);
    int g;
    in_valid_i <= 1'b1;
    in_high_i <= hi;
    in_low_i <= lo;
    in_count_i <= cnt;
    in_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_cts(hi, lo, cnt, last);
    items_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_msg(input int nfull, input logic [4:0] last_cnt);
    for (int i = 0; i < nfull; i++)
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, last_cnt, 1'b1);
  endtask

  // wait for every expected transfer plus the block's own latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_ct.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegKeyHigh: key_reg[127:64] = data;
      RegKeyLow:  key_reg[63:0] = data;
      RegIvHigh:  iv_reg[127:64] = data;
      RegIvLow:   iv_reg[63:0] = data;
      RegVariant: variant_reg = data[1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_block('0, '0, 5'd16, 1'b1);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd8, 1'b1);
    drain();
  endtask

  task automatic test_variants();
    cfg_write(RegKeyHigh, '1);
    cfg_write(RegKeyLow, '1);
    cfg_write(RegIvHigh, '1);
    cfg_write(RegIvLow, '1);
    cfg_write(RegVariant, 64'(VarCs1));
    send_msg(1, 5'd7);
    send_msg(1, 5'd16);
    drain();
    cfg_write(RegVariant, 64'(VarCs2));
    send_msg(1, 5'd16);
    send_msg(2, 5'd9);
    drain();
    cfg_write(RegVariant, 64'(VarCs3));
    send_msg(1, 5'd1);
    drain();
    cfg_write(RegVariant, 64'(VarUnused));
    send_msg(1, 5'd15);
    drain();
  endtask

  task automatic test_error_cases();
    cfg_write(RegKeyHigh, '0);
    cfg_write(RegIvLow, '0);
    cfg_write(RegVariant, 64'(VarCs1));
    // message shorter than a block, and counts outside 1..16
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd3, 1'b1);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b1);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd31, 1'b1);
    // short block that is not last drops the held block
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
    send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd4, 1'b0);
    send_msg(1, 5'd17);
    drain();
  endtask

  // receiver holds off so the block backs up, then the sender waits for all
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    send_msg(6, 5'd11);
    drain();
  endtask

  task automatic test_random_msgs();
    logic [63:0] v;
    while (items_sent < 570) begin
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 85) begin
        send_msg($urandom_range(0, 9) == 0 ? $urandom_range(5, 8) : $urandom_range(0, 3),
                 $urandom_range(0, 4) == 0 ? 5'd16 : 5'($urandom_range(1, 16)));
      end else begin
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(0, 31)),
                   1'($urandom));
      end
      if ($urandom_range(0, 14) == 0) begin
        quiet = 1'b0;
        drain();
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom, $urandom};
        endcase
        cfg_write(3'($urandom_range(0, 3)), v);
        cfg_write(RegVariant, 64'($urandom_range(0, 3)));
      end
    end
    quiet = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_variants();
    test_error_cases();
    test_backpressure();
    test_random_msgs();
    drain();
    if (fails == 0 && pending_ct.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
